// File: rtl/wstp_pkg.sv
// Package for the weekly schedule text parser.
// Holds the store geometry, character codes, status codes and the result beat type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wstp_pkg;

   localparam int NUM_DAYS       = 7;
   localparam int EVENTS_PER_DAY = 4;
   localparam int STORE_DEPTH    = NUM_DAYS * EVENTS_PER_DAY;
   localparam int IDX_W          = $clog2(STORE_DEPTH);

   localparam int CHAR_W    = 8;
   localparam int DAY_W     = 3;
   localparam int EVENT_W   = 2;
   localparam int LINES_W   = 3;
   localparam int MINUTES_W = 11;
   localparam int HOURS_W   = 5;
   localparam int POS_W     = 3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_LAST   = 8'h39;
   localparam logic [CHAR_W-1:0] COMMENT_CHAR = 8'h23;
   localparam logic [CHAR_W-1:0] SEP_CHAR     = 8'h7C;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

   localparam logic [6:0] MAX_HOUR   = 7'd23;
   localparam logic [6:0] MAX_MINUTE = 7'd59;

   localparam logic [LINES_W-1:0] DAYS_CODE  = LINES_W'(NUM_DAYS);
   localparam logic [EVENT_W-1:0] LAST_EVENT = EVENT_W'(EVENTS_PER_DAY - 1);

   // Positions within one HHMM field and its separator.
   localparam logic [POS_W-1:0] POS_HOUR_TENS   = 3'd0;
   localparam logic [POS_W-1:0] POS_HOUR_ONES   = 3'd1;
   localparam logic [POS_W-1:0] POS_MINUTE_TENS = 3'd2;
   localparam logic [POS_W-1:0] POS_MINUTE_ONES = 3'd3;
   localparam logic [POS_W-1:0] POS_SEPARATOR   = 3'd4;

   typedef enum logic {
      ACTION_FEED   = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_FIELD  = 2'd1,
      STATUS_LINE_COUNT = 2'd2
   } status_type;

   typedef struct packed {
      logic                 parse_done;
      status_type           parse_status;
      logic [LINES_W-1:0]   lines_done;
      logic [MINUTES_W-1:0] lookup_minutes;
      logic                 lookup_valid;
   } result_type;

   // ASCII digit check.
   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      is_digit = (c >= DIGIT_BASE) && (c <= DIGIT_LAST);
   endfunction

   // Value of two ASCII digits, 0 to 99; tens times ten is two shifts.
   function automatic logic [6:0] two_digit_value(input logic [CHAR_W-1:0] tens,
                                                  input logic [CHAR_W-1:0] ones);
      logic [6:0] t;
      logic [6:0] o;
      t = {3'b000, tens[3:0]};
      o = {3'b000, ones[3:0]};
      two_digit_value = (t << 3) + (t << 1) + o;
   endfunction

endpackage

`default_nettype wire

// File: rtl/weekly_schedule_text_parser.sv
// Top level of the weekly schedule text parser: byte decoder, schedule store and
// result register with skid stage. Depends on wstp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata char, day, event; tuser action; tlast last byte
// rsp      out  rsp_tvalid/rsp_tready  tdata status, lines, minutes; tuser valid; tlast done
//
// One beat is taken per cycle while req_tready is high; its result goes to the output register,
// or to the skid slot while the output is stalled. The byte decoder ahead of it is combinational.
// Reset clears the parse state, the 28-entry store (flip-flops) and both slots' valid flags.
// A skid slot holds one result while the output is stalled; req_tready drops only
// when that slot is full.

module weekly_schedule_text_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [wstp_pkg::REQ_DATA_W-1:0]   req_tdata,   // char_in[7:0],
                                                               // query_day[10:8],
                                                               // query_event[12:11]
   input  wire logic                              req_tuser,   // action
   input  wire logic                              req_tlast,   // last_byte

   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [wstp_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // parse_status[1:0],
                                                               // lines_done[4:2],
                                                               // lookup_minutes[15:5]
   output logic                                   rsp_tuser,   // lookup_valid
   output logic                                   rsp_tlast    // parse_done
);

   logic [wstp_pkg::CHAR_W-1:0]    char_in;
   logic [wstp_pkg::DAY_W-1:0]     query_day;
   logic [wstp_pkg::EVENT_W-1:0]   query_event;
   wstp_pkg::action_type           action;
   logic                           accept;
   logic                           out_take;

   logic [wstp_pkg::MINUTES_W-1:0] store_ff [wstp_pkg::STORE_DEPTH];
   logic                           store_we;
   logic [wstp_pkg::IDX_W-1:0]     store_waddr;
   logic [wstp_pkg::MINUTES_W-1:0] store_wdata;

   logic [wstp_pkg::CHAR_W-1:0]    prev_char_ff, prev_char_in;
   logic [wstp_pkg::POS_W-1:0]     field_pos_ff, field_pos_in;
   logic [wstp_pkg::EVENT_W-1:0]   event_ff, event_in;
   logic [wstp_pkg::LINES_W-1:0]   lines_ff, lines_in;
   logic                           overflow_ff, overflow_in;
   logic                           comment_ff, comment_in;
   logic [wstp_pkg::HOURS_W-1:0]   hours_ff, hours_in;
   logic                           error_ff, error_in;

   logic [6:0]                     pair_value;
   logic                           pair_digits;
   logic [wstp_pkg::IDX_W-1:0]     lookup_full;
   logic                           day_ok;
   wstp_pkg::result_type           result;

   wstp_pkg::result_type           out_ff, out_in;
   logic                           out_valid_ff, out_valid_in;
   wstp_pkg::result_type           skid_ff, skid_in;
   logic                           skid_valid_ff, skid_valid_in;

   assign char_in     = req_tdata[7:0];
   assign query_day   = req_tdata[10:8];
   assign query_event = req_tdata[12:11];
   assign action      = wstp_pkg::action_type'(req_tuser);

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;

   assign pair_value  = wstp_pkg::two_digit_value(prev_char_ff, char_in);
   assign pair_digits = wstp_pkg::is_digit(prev_char_ff) && wstp_pkg::is_digit(char_in);

   // Byte decoder: next parse state, store write and the result of this beat.
   always_comb begin
      prev_char_in = prev_char_ff;
      field_pos_in = field_pos_ff;
      event_in     = event_ff;
      lines_in     = lines_ff;
      overflow_in  = overflow_ff;
      comment_in   = comment_ff;
      hours_in     = hours_ff;
      error_in     = error_ff;
      store_we     = 1'b0;
      store_waddr  = wstp_pkg::IDX_W'({lines_ff, event_ff});
      store_wdata  = ({6'b0, hours_ff} << 6) - ({6'b0, hours_ff} << 2)
                     + {4'b0, pair_value};
      result       = '0;
      lookup_full  = {query_day, query_event};
      day_ok       = query_day < wstp_pkg::DAY_W'(wstp_pkg::NUM_DAYS);

      if (action == wstp_pkg::ACTION_FEED) begin
         prev_char_in = char_in;
         if (!error_ff) begin
            if (comment_ff) begin
               if (char_in == wstp_pkg::NEWLINE_CHAR) begin
                  comment_in = 1'b0;
               end
            end else if (char_in == wstp_pkg::COMMENT_CHAR) begin
               comment_in = 1'b1;
            end else begin
               case (field_pos_ff)
                  wstp_pkg::POS_HOUR_ONES: begin
                     if (!pair_digits || pair_value > wstp_pkg::MAX_HOUR) begin
                        error_in = 1'b1;
                     end else begin
                        hours_in     = pair_value[wstp_pkg::HOURS_W-1:0];
                        field_pos_in = wstp_pkg::POS_MINUTE_TENS;
                     end
                  end
                  wstp_pkg::POS_MINUTE_ONES: begin
                     if (!pair_digits || pair_value > wstp_pkg::MAX_MINUTE) begin
                        error_in = 1'b1;
                     end else begin
                        store_we = lines_ff < wstp_pkg::DAYS_CODE;
                        if (event_ff == wstp_pkg::LAST_EVENT) begin
                           // Line complete; whatever follows on it is skipped.
                           if (lines_ff < wstp_pkg::DAYS_CODE) begin
                              lines_in = lines_ff + wstp_pkg::LINES_W'(1);
                           end else begin
                              overflow_in = 1'b1;
                           end
                           event_in     = '0;
                           field_pos_in = wstp_pkg::POS_HOUR_TENS;
                           comment_in   = 1'b1;
                        end else begin
                           field_pos_in = wstp_pkg::POS_SEPARATOR;
                        end
                     end
                  end
                  wstp_pkg::POS_SEPARATOR: begin
                     if (char_in == wstp_pkg::SEP_CHAR) begin
                        field_pos_in = wstp_pkg::POS_HOUR_TENS;
                        event_in     = event_ff + wstp_pkg::EVENT_W'(1);
                     end else begin
                        error_in = 1'b1;
                     end
                  end
                  default: begin
                     field_pos_in = field_pos_ff + wstp_pkg::POS_W'(1);
                  end
               endcase
            end
         end

         result.lines_done = lines_in;
         if (req_tlast) begin
            result.parse_done = 1'b1;
            if (error_in) begin
               result.parse_status = wstp_pkg::STATUS_BAD_FIELD;
            end else if (overflow_in || lines_in != wstp_pkg::DAYS_CODE) begin
               result.parse_status = wstp_pkg::STATUS_LINE_COUNT;
            end else begin
               result.parse_status = wstp_pkg::STATUS_OK;
            end
            prev_char_in = '0;
            field_pos_in = '0;
            event_in     = '0;
            lines_in     = '0;
            overflow_in  = 1'b0;
            comment_in   = 1'b0;
            hours_in     = '0;
            error_in     = 1'b0;
         end
      end else begin
         result.lines_done = lines_ff;
         if (day_ok) begin
            result.lookup_valid   = 1'b1;
            result.lookup_minutes = store_ff[lookup_full];
         end
      end
   end

   // Output register and skid slot.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff  <= '0;
         field_pos_ff  <= '0;
         event_ff      <= '0;
         lines_ff      <= '0;
         overflow_ff   <= 1'b0;
         comment_ff    <= 1'b0;
         hours_ff      <= '0;
         error_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < wstp_pkg::STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            prev_char_ff <= prev_char_in;
            field_pos_ff <= field_pos_in;
            event_ff     <= event_in;
            lines_ff     <= lines_in;
            overflow_ff  <= overflow_in;
            comment_ff   <= comment_in;
            hours_ff     <= hours_in;
            error_ff     <= error_in;
            if (store_we) begin
               store_ff[store_waddr] <= store_wdata;
            end
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.lookup_minutes, out_ff.lines_done, out_ff.parse_status};
   assign rsp_tuser  = out_ff.lookup_valid;
   assign rsp_tlast  = out_ff.parse_done;

endmodule

`default_nettype wire
